// ===== src/cpf_pkg.sv =====
// Package for the critical path forward pass core: sizes, command codes,
// and the structs passed between the input stage, finish table and scheduler.
// No dependencies.
package cpf_pkg;

  localparam int unsigned MAX_TASKS     = 256;
  localparam int unsigned TASK_BITS     = $clog2(MAX_TASKS);
  localparam int unsigned DUR_BITS      = 16;
  localparam int unsigned TIME_BITS     = 24;
  localparam int unsigned IN_DATA_BITS  = 40;
  localparam int unsigned OUT_DATA_BITS = 80;

  typedef logic [TASK_BITS-1:0] task_t;
  typedef logic [DUR_BITS-1:0]  dur_t;
  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  // Beat kind carried on tuser
  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_TASK  = 1'b1
  } cmd_e;

  // One accepted input beat
  typedef struct packed {
    cmd_e  cmd;
    task_t task_idx;
    dur_t  dur;
    logic  has_pred;
    task_t pred;
    logic  last;
  } item_t;

  // Finish table write port
  typedef struct packed {
    logic  en;
    task_t addr;
    time_t data;
  } wr_t;

  // One result beat
  typedef struct packed {
    time_t span_so_far;
    time_t finish_time;
    time_t start_time;
    task_t done_task;
  } result_t;

endpackage

// ===== src/critical_path_forward_pass_core.sv =====
// A task beat with tlast passes the input register, with the table read,
// then the result register, and waits in the input register while a result
// is held. Throughput: one input beat per cycle, set by the single finish
// table read port plus a forward of the finish time written at the read edge,
// while no committing beat waits. Reset clears the scheduled flags, running start,
// makespan and valids; the finish table is not cleared, only read behind a set flag.
module critical_path_forward_pass_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: task_index[7:0], duration[23:8], has_pred[24], pred_index[32:25], zero pad
  input  logic [cpf_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: command[0]
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: done_task[7:0], start_time[31:8], finish_time[55:32], span_so_far[79:56]
  output logic [cpf_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);

  localparam int unsigned DurLo  = cpf_pkg::TASK_BITS;
  localparam int unsigned HasPos = DurLo + cpf_pkg::DUR_BITS;
  localparam int unsigned PrdLo  = HasPos + 1;

  logic            accept;
  logic            s1_valid_q;
  cpf_pkg::item_t  item_d;
  cpf_pkg::item_t  item_q;
  logic            fwd_hit_q;
  cpf_pkg::time_t  fwd_data_q;
  cpf_pkg::time_t  ram_data;
  cpf_pkg::time_t  pred_fin;
  cpf_pkg::wr_t    wr;
  logic            s1_fire;

  // Unpack the input beat
  assign item_d.cmd      = cpf_pkg::cmd_e'(s_axis_tuser);
  assign item_d.task_idx = s_axis_tdata[cpf_pkg::TASK_BITS-1:0];
  assign item_d.dur      = s_axis_tdata[HasPos-1:DurLo];
  assign item_d.has_pred = s_axis_tdata[HasPos];
  assign item_d.pred     = s_axis_tdata[PrdLo+cpf_pkg::TASK_BITS-1:PrdLo];
  assign item_d.last     = s_axis_tlast;

  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Input payload and forward of a same-edge table write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= item_d;
      fwd_hit_q  <= wr.en && (wr.addr == item_d.pred);
      fwd_data_q <= wr.data;
    end
  end

  cpf_finish_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (item_d.pred),
    .rd_data_o (ram_data)
  );

  assign pred_fin = fwd_hit_q ? fwd_data_q : ram_data;

  cpf_sched u_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q),
    .item_i     (item_q),
    .pred_fin_i (pred_fin),
    .fire_o     (s1_fire),
    .wr_o       (wr),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule

// ===== src/cpf_finish_ram.sv =====
// Finish time table: one write port, one registered read port.
// Contents are undefined until written; readers qualify with scheduled flags.
// Depends on cpf_pkg.
module cpf_finish_ram (
  input  logic            clk_i,
  input  cpf_pkg::wr_t    wr_i,
  input  logic            rd_en_i,
  input  cpf_pkg::task_t  rd_addr_i,
  output cpf_pkg::time_t  rd_data_o
);

  cpf_pkg::time_t mem [cpf_pkg::MAX_TASKS];
  cpf_pkg::time_t rd_data_q;

  // Write, then read-old on the same edge
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/cpf_sched.sv =====
// Scheduler stage: scheduled flags, running start max, makespan, finish
// computation and the result register. Depends on cpf_pkg.
module cpf_sched (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  cpf_pkg::item_t                       item_i,
  input  cpf_pkg::time_t                       pred_fin_i,
  output logic                                 fire_o,
  output cpf_pkg::wr_t                         wr_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [cpf_pkg::OUT_DATA_BITS-1:0]    m_data_o
);

  logic [cpf_pkg::MAX_TASKS-1:0] flags_q;
  cpf_pkg::time_t                run_q;
  cpf_pkg::time_t                span_q;
  logic                          out_valid_q;
  cpf_pkg::result_t              res_q;

  logic                          is_clear;
  logic                          commit;
  logic                          out_free;
  logic                          pred_ok;
  cpf_pkg::time_t                cand;
  logic [cpf_pkg::TIME_BITS:0]   sum;
  cpf_pkg::time_t                finish;
  cpf_pkg::time_t                span_new;

  // Decode and handshake
  assign is_clear = (item_i.cmd == cpf_pkg::CMD_CLEAR);
  assign commit   = (item_i.cmd == cpf_pkg::CMD_TASK) && item_i.last;
  assign out_free = !out_valid_q || m_ready_i;
  assign fire_o   = valid_i && (!commit || out_free);

  // Start max, saturating finish, makespan
  assign pred_ok  = item_i.has_pred && flags_q[item_i.pred];
  assign cand     = (pred_ok && (pred_fin_i > run_q)) ? pred_fin_i : run_q;
  assign sum      = {1'b0, cand} + {{(cpf_pkg::TIME_BITS + 1 - cpf_pkg::DUR_BITS){1'b0}},
                                    item_i.dur};
  assign finish   = sum[cpf_pkg::TIME_BITS] ? cpf_pkg::TIME_MAX
                                            : sum[cpf_pkg::TIME_BITS-1:0];
  assign span_new = (finish > span_q) ? finish : span_q;

  // Table write on commit
  assign wr_o.en   = fire_o && commit;
  assign wr_o.addr = item_i.task_idx;
  assign wr_o.data = finish;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      run_q       <= '0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_o) begin
        if (is_clear) begin
          flags_q <= '0;
          run_q   <= '0;
          span_q  <= '0;
        end else if (commit) begin
          flags_q[item_i.task_idx] <= 1'b1;
          run_q                    <= '0;
          span_q                   <= span_new;
        end else begin
          run_q <= cand;
        end
      end
      if (out_free) begin
        out_valid_q <= fire_o && commit;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire_o && commit) begin
      res_q.done_task   <= item_i.task_idx;
      res_q.start_time  <= cand;
      res_q.finish_time <= finish;
      res_q.span_so_far <= span_new;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = res_q;

`ifndef SYNTHESIS
  a_no_result_without_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && !commit && out_free) |=> !out_valid_q)
    else $error("result raised without a committing beat");
  a_clear_empties_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && is_clear) |=> (span_q == '0) && (run_q == '0) && (flags_q == '0))
    else $error("clear did not empty schedule state");
  a_finish_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.finish_time >= res_q.start_time))
    else $error("finish earlier than start");
  a_span_covers_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.span_so_far >= res_q.finish_time))
    else $error("makespan below task finish");
`endif

endmodule
